// ===== design/assert_macros.svh =====
// ============================================================================
// assert_macros.svh - shared concurrent assertion macros
// Clocked, reset-qualified property wrappers used by the prd_checker file.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

`endif

// ===== design/prd_pkg.sv =====
// ============================================================================
// prd_pkg - padded record deframer package
// Types and constants shared by the deframer modules.
// ============================================================================
package prd_pkg;

    // Record count before raw passthrough, after reset
    localparam logic [7:0] PRD_RECORDS_RESET = 8'd8;

    // Item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // End of stream status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_PADDING = 2'd2,
        PH_RAW     = 2'd3
    } prd_phase_t;

    typedef struct packed {
        prd_phase_t  phase;
        logic [1:0]  hdr_seen;
        logic [15:0] payload_left;
        logic [7:0]  padding_left;
        logic [7:0]  records_done;
        logic        truncated;
    } prd_state_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] out_byte;
        logic       status;
    } prd_result_t;

endpackage

// ===== design/prd_if.sv =====
// ============================================================================
// prd_if - deframer channel interfaces
// Valid/ready channels for input bytes, results and the config write.
// ============================================================================
interface prd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_byte;

    modport source (output valid, output kind, output in_byte, input ready);
    modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface prd_out_if;
    logic       valid;
    logic       ready;
    logic       is_status;
    logic [7:0] out_byte;
    logic       status;

    modport source (output valid, output is_status, output out_byte, output status,
                    input ready);
    modport sink   (input valid, input is_status, input out_byte, input status,
                    output ready);
endinterface

interface prd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/prd_step.sv =====
// ============================================================================
// prd_step - deframer decode step
// Next framing state and optional result for one accepted request.
// ============================================================================
module prd_step
    import prd_pkg::*;
(
    input  prd_state_t  cur,
    input  logic        kind,
    input  logic [7:0]  in_byte,
    input  logic [7:0]  padded_records,
    output prd_state_t  nxt,
    output logic        res_valid,
    output prd_result_t res
);

    logic at_boundary;

    // Record complete: bump count, clear counters, maybe switch to raw
    function automatic prd_state_t finish_record(prd_state_t s, logic [7:0] limit);
        prd_state_t r;
        r              = s;
        r.records_done = s.records_done + 8'd1;
        r.hdr_seen     = 2'd0;
        r.payload_left = 16'd0;
        r.padding_left = 8'd0;
        r.phase        = (r.records_done == limit) ? PH_RAW : PH_HEADER;
        return r;
    endfunction

    assign at_boundary = (cur.phase == PH_RAW) ||
                         ((cur.phase == PH_HEADER) && (cur.hdr_seen == 2'd0));

    // Next state
    always_comb
    begin
        nxt = cur;
        if (kind == KIND_EOS)
        begin
            if (!at_boundary)
                nxt.truncated = 1'b1;
        end
        else if (!cur.truncated)
        begin
            unique case (cur.phase)
                PH_RAW:
                begin
                    nxt = cur;
                end
                PH_HEADER:
                begin
                    priority case (cur.hdr_seen)
                        2'd0:
                        begin
                            nxt.payload_left = {in_byte, 8'h00};
                            nxt.hdr_seen     = 2'd1;
                        end
                        2'd1:
                        begin
                            nxt.payload_left = cur.payload_left | {8'h00, in_byte};
                            nxt.hdr_seen     = 2'd2;
                        end
                        default:
                        begin
                            // third header byte: padding length
                            nxt.padding_left = in_byte;
                            nxt.hdr_seen     = 2'd0;
                            if (cur.payload_left != 16'd0)
                                nxt.phase = PH_PAYLOAD;
                            else if (in_byte != 8'd0)
                                nxt.phase = PH_PADDING;
                            else
                                nxt = finish_record(cur, padded_records);
                        end
                    endcase
                end
                PH_PAYLOAD:
                begin
                    if (cur.payload_left <= 16'd1)
                    begin
                        nxt.payload_left = 16'd0;
                        if (cur.padding_left == 8'd0)
                            nxt = finish_record(cur, padded_records);
                        else
                            nxt.phase = PH_PADDING;
                    end
                    else
                        nxt.payload_left = cur.payload_left - 16'd1;
                end
                PH_PADDING:
                begin
                    if (cur.padding_left <= 8'd1)
                        nxt = finish_record(cur, padded_records);
                    else
                        nxt.padding_left = cur.padding_left - 8'd1;
                end
            endcase
        end
    end

    // Result
    always_comb
    begin
        res.is_status = kind;
        res.out_byte  = (kind == KIND_EOS) ? 8'h00 : in_byte;
        res.status    = STATUS_OK;
        if (kind == KIND_EOS)
        begin
            res_valid  = 1'b1;
            res.status = (cur.truncated || !at_boundary) ? STATUS_TRUNCATED : STATUS_OK;
        end
        else
            res_valid = !cur.truncated &&
                        ((cur.phase == PH_RAW) || (cur.phase == PH_PAYLOAD));
    end

endmodule

// ===== design/padded_record_deframer.sv =====
// ============================================================================
// padded_record_deframer - length-prefixed padded record deframer
// Strips 3-byte headers and padding from a byte stream, then passes raw.
// ============================================================================
// Usage:
//   rx  : one request per byte (kind 0) or end-of-stream check (kind 1).
//   tx  : payload/raw bytes and end-of-stream status answers.
//   cfg : write of padded_records, taken at any cycle (ready is tied high);
//         write only while the block is idle.
// Header bytes, padding bytes and data after a truncation give no result.
// Latency: a result shows on tx the cycle after its request is accepted.
// Throughput: one request per cycle while rx is ready; the decode step is a single pass of
//   counter logic between the framing state register and the tx register.
// tx is held in one output register; rx stays ready while that register
//   is empty or being taken, so a stalled receiver holds rx off only once
//   a result is already waiting.
// Reset: framing state clears to the header phase with no records done,
//   no sticky error, padded_records back to 8, and tx empty.
// ============================================================================
module padded_record_deframer
    import prd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    prd_in_if.sink    rx,
    prd_out_if.source tx,
    prd_cfg_if.sink   cfg
);

    prd_state_t  state_reg;
    prd_state_t  state_next;
    logic [7:0]  records_cfg_reg;
    logic        out_valid_reg;
    prd_result_t out_reg;
    prd_result_t res;
    logic        res_valid;
    logic        accept;

    // Decode step
    prd_step u_step (
        .cur            (state_reg),
        .kind           (rx.kind),
        .in_byte        (rx.in_byte),
        .padded_records (records_cfg_reg),
        .nxt            (state_next),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Handshakes
    assign rx.ready  = !out_valid_reg || tx.ready;
    assign accept    = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            records_cfg_reg <= PRD_RECORDS_RESET;
        else if (cfg.valid)
            records_cfg_reg <= cfg.data;
    end

    // Framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_HEADER;
            state_reg.hdr_seen     <= 2'd0;
            state_reg.payload_left <= 16'd0;
            state_reg.padding_left <= 8'd0;
            state_reg.records_done <= 8'd0;
            state_reg.truncated    <= 1'b0;
        end
        else if (accept)
            state_reg <= state_next;
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= res_valid;
        else if (tx.ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_reg <= res;
    end

    assign tx.valid     = out_valid_reg;
    assign tx.is_status = out_reg.is_status;
    assign tx.out_byte  = out_reg.out_byte;
    assign tx.status    = out_reg.status;

endmodule

// ===== design/prd_checker.sv =====
// ============================================================================
// prd_checker - port-level assertions for the deframer
// Result field rules, stall behavior and sticky truncation on the ports.
// ============================================================================
`include "assert_macros.svh"

module prd_checker
    import prd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rx_ready,
    input logic       tx_valid,
    input logic       tx_ready,
    input logic       tx_is_status,
    input logic [7:0] tx_out_byte,
    input logic       tx_status
);

    // Empty output register never holds off the sender
    `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !tx_valid, rx_ready)

    // Status answers carry a zero byte, data results carry ok
    `ASSERT_IMPLY(a_status_byte_zero, clk, rst_n, tx_valid && tx_is_status,
                  tx_out_byte == 8'h00)
    `ASSERT_IMPLY(a_data_status_ok, clk, rst_n, tx_valid && !tx_is_status,
                  tx_status == STATUS_OK)

    // No data result follows a truncated answer
    `ASSERT_NEXT(a_trunc_sticky, clk, rst_n,
                 tx_valid && tx_ready && tx_is_status && (tx_status == STATUS_TRUNCATED),
                 !(tx_valid && !tx_is_status))

    // Stalled result holds
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, tx_valid && !tx_ready,
                 tx_valid && $stable(tx_out_byte))

endmodule

bind padded_record_deframer prd_checker u_prd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_ready     (rx.ready),
    .tx_valid     (tx.valid),
    .tx_ready     (tx.ready),
    .tx_is_status (tx.is_status),
    .tx_out_byte  (tx.out_byte),
    .tx_status    (tx.status)
);

// ===== verif/padded_record_deframer_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// padded_record_deframer_checker - deframer output checker
// Watches the rx, tx and cfg channels, keeps its own copy of the framing
// state and record limit, predicts the tx output of every rx request and
// compares each tx request field by field against the oldest prediction.
// ============================================================================
module padded_record_deframer_checker
    import prd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    prd_in_if    rx,
    prd_out_if   tx,
    prd_cfg_if   cfg,
    output int   errors,
    output int   pending
);

    prd_state_t  frame;
    logic [7:0]  record_limit;
    prd_result_t due_outputs[$];
    int          mismatch_count;

    assign errors = mismatch_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t: deframer mismatch: %s", $time, what);
    endtask

    // Record done: bump the wrapping count, go raw once it hits the limit
    function void close_record();
        frame.records_done = frame.records_done + 8'd1;
        frame.hdr_seen     = 2'd0;
        frame.payload_left = 16'd0;
        frame.padding_left = 8'd0;
        if (frame.records_done == record_limit)
            frame.phase = PH_RAW;
        else
            frame.phase = PH_HEADER;
    endfunction

    // Advance the framing state by one rx request, queue any output it owes
    task automatic deframe_step(input logic kind, input logic [7:0] value);
        prd_result_t res;
        res.is_status = 1'b0;
        res.out_byte  = value;
        res.status    = STATUS_OK;
        if (kind == KIND_EOS) begin
            // Mid record means truncated; raw or a clean boundary is fine
            if (!frame.truncated && !(frame.phase == PH_RAW ||
                (frame.phase == PH_HEADER && frame.hdr_seen == 2'd0)))
                frame.truncated = 1'b1;
            res.is_status = 1'b1;
            res.out_byte  = 8'd0;
            res.status    = frame.truncated ? STATUS_TRUNCATED : STATUS_OK;
            due_outputs.push_back(res);
        end
        else if (!frame.truncated) begin
            case (frame.phase)
                PH_RAW: due_outputs.push_back(res);
                PH_HEADER:
                begin
                    if (frame.hdr_seen == 2'd0) begin
                        frame.payload_left = {value, 8'h00};
                        frame.hdr_seen     = 2'd1;
                    end
                    else if (frame.hdr_seen == 2'd1) begin
                        frame.payload_left = frame.payload_left | {8'h00, value};
                        frame.hdr_seen     = 2'd2;
                    end
                    else begin
                        frame.padding_left = value;
                        frame.hdr_seen     = 2'd0;
                        if (frame.payload_left != 16'd0)
                            frame.phase = PH_PAYLOAD;
                        else if (value != 8'd0)
                            frame.phase = PH_PADDING;
                        else
                            close_record();
                    end
                end
                PH_PAYLOAD:
                begin
                    due_outputs.push_back(res);
                    if (frame.payload_left <= 16'd1) begin
                        frame.payload_left = 16'd0;
                        if (frame.padding_left == 8'd0)
                            close_record();
                        else
                            frame.phase = PH_PADDING;
                    end
                    else begin
                        frame.payload_left = frame.payload_left - 16'd1;
                    end
                end
                default:
                begin
                    // padding is dropped
                    if (frame.padding_left <= 8'd1)
                        close_record();
                    else
                        frame.padding_left = frame.padding_left - 8'd1;
                end
            endcase
        end
    endtask

    task automatic match_output();
        prd_result_t want;
        if (due_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected output byte %02h status %0b",
                                      tx.out_byte, tx.status));
        end
        else begin
            want = due_outputs.pop_front();
            if (tx.is_status !== want.is_status)
                report_mismatch($sformatf("is_status %0b, want %0b",
                                          tx.is_status, want.is_status));
            if (tx.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h",
                                          tx.out_byte, want.out_byte));
            if (tx.status !== want.status)
                report_mismatch($sformatf("status %0b, want %0b",
                                          tx.status, want.status));
        end
    endtask

    // tx is checked before rx: a request accepted now shows on tx in the next cycle.
    // A cfg write applies from the next rx request on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame          = '0;
            record_limit   = PRD_RECORDS_RESET;
            mismatch_count = 0;
            due_outputs.delete();
            pending <= 0;
        end
        else begin
            if (tx.valid && tx.ready)
                match_output();
            if (rx.valid && rx.ready)
                deframe_step(rx.kind, rx.in_byte);
            if (cfg.valid && cfg.ready)
                record_limit = cfg.data;
            pending <= due_outputs.size();
        end
    end

endmodule

// ===== verif/padded_record_deframer_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// padded_record_deframer_tb - deframer testbench top
// Drives framed byte streams with bursty rx traffic and a stalling tx
// receiver, rewrites the record limit between phases, and ends either in
// raw passthrough or with a truncated record, chosen per seed.
// ============================================================================
module padded_record_deframer_tb;
    import prd_pkg::*;

    logic       clk;
    logic       rst_n;
    int         check_errors;
    int         pending;
    int         burst_left;
    int         hold_asks;
    int         hold_seen;
    int         hold_left;
    int         rx_mode;
    int         rx_mode_left;
    logic [7:0] records_sent;

    prd_in_if  rx_ch();
    prd_out_if tx_ch();
    prd_cfg_if cfg_ch();

    padded_record_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch),
        .cfg   (cfg_ch)
    );

    padded_record_deframer_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .tx      (tx_ch),
        .cfg     (cfg_ch),
        .errors  (check_errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Run limit, far above the slowest correct run
    initial
    begin
        #2400000;
        $display("padded_record_deframer_tb: errors");
        $finish;
    end

    // tx receiver: stall pattern changes mode now and then; long holds on request or at random
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            tx_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_asks != hold_seen || $urandom_range(0, 4999) == 0) begin
            hold_seen   = hold_asks;
            hold_left   = 400;
            tx_ch.ready <= 1'b0;
        end
        else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left = rx_mode_left - 1;
            case (rx_mode)
                0:       tx_ch.ready <= 1'b1;
                1:       tx_ch.ready <= 1'($urandom_range(0, 1));
                2:       tx_ch.ready <= ($urandom_range(0, 3) == 0);
                default: tx_ch.ready <= ~tx_ch.ready;
            endcase
        end
    end

    // One rx request; bursts of random length with random gaps between
    task automatic send_item(input logic kind, input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left = burst_left - 1;
        rx_ch.valid   <= 1'b1;
        rx_ch.kind    <= kind;
        rx_ch.in_byte <= value;
        do @(posedge clk); while (!rx_ch.ready);
    endtask

    // Stop sending until every owed output has come out or max_cycles pass, plus the pipe delay
    task automatic drain_results(input int max_cycles);
        int waited;
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        for (waited = 0; waited < max_cycles && pending != 0; waited++)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_record_limit(input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_record(input logic [15:0] len, input logic [7:0] pad);
        send_item(KIND_DATA, len[15:8]);
        send_item(KIND_DATA, len[7:0]);
        send_item(KIND_DATA, pad);
        repeat (len) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        repeat (pad) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        records_sent = records_sent + 8'd1;
    endtask

    // Well-formed record with random sizes, sometimes an EOS check or a drain
    task automatic random_record(input int max_len, input int max_pad);
        send_record(16'($urandom_range(0, max_len)), 8'($urandom_range(0, max_pad)));
        if ($urandom_range(0, 7) == 0)
            send_item(KIND_EOS, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 24) == 0)
            drain_results(20000);
    endtask

    initial
    begin
        int cut;
        int len;
        int pad;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.kind    = KIND_DATA;
        rx_ch.in_byte = 8'd0;
        tx_ch.ready   = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = 8'd0;
        burst_left    = 0;
        hold_asks     = 0;
        hold_seen     = 0;
        hold_left     = 0;
        rx_mode       = 0;
        rx_mode_left  = 0;
        records_sent  = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset limit, EOS at start, empty records, byte extremes
        send_item(KIND_EOS, 8'hFF);
        send_record(16'd0, 8'd0);
        send_item(KIND_EOS, 8'h00);
        send_record(16'd0, 8'd2);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'h02);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h00);
        records_sent = records_sent + 8'd1;
        send_record(16'd1, 8'd1);
        send_item(KIND_EOS, 8'h5A);
        random_record(12, 4);
        random_record(12, 4);
        drain_results(20000);

        // Top limit; also 256-byte payload and 255 bytes of padding
        write_record_limit(8'd255);
        send_record(16'h0100, 8'd3);
        send_record(16'd5, 8'hFF);
        repeat (4) random_record(24, 6);
        drain_results(20000);

        // Mid limit, out of reach here; receiver holds off while rx keeps going
        write_record_limit(8'($urandom_range(records_sent + 40, 200)));
        hold_asks <= hold_asks + 1;
        repeat (6) random_record(24, 6);
        drain_results(20000);

        // Limit 1 sits below the count, so raw mode waits for the wrap
        write_record_limit(8'd1);
        if ($urandom_range(0, 1) == 0) begin
            // Ending in raw passthrough
            do random_record(1, 1); while (records_sent != 8'd1);
            repeat (100)
                send_item(($urandom_range(0, 7) == 0) ? KIND_EOS : KIND_DATA,
                          8'($urandom_range(0, 255)));
        end
        else begin
            // Ending with a truncated record; the error sticks for good
            repeat (200) random_record(1, 1);
            cut = $urandom_range(0, 3);
            case (cut)
                0: send_item(KIND_DATA, 8'($urandom_range(0, 255)));
                1:
                begin
                    send_item(KIND_DATA, 8'($urandom_range(0, 255)));
                    send_item(KIND_DATA, 8'($urandom_range(0, 255)));
                end
                2:
                begin
                    len = $urandom_range(2, 20);
                    send_item(KIND_DATA, 8'd0);
                    send_item(KIND_DATA, 8'(len));
                    send_item(KIND_DATA, 8'($urandom_range(0, 5)));
                    repeat ($urandom_range(1, len - 1))
                        send_item(KIND_DATA, 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    len = $urandom_range(0, 5);
                    pad = $urandom_range(2, 20);
                    send_item(KIND_DATA, 8'd0);
                    send_item(KIND_DATA, 8'(len));
                    send_item(KIND_DATA, 8'(pad));
                    repeat (len) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
                    repeat ($urandom_range(1, pad - 1))
                        send_item(KIND_DATA, 8'($urandom_range(0, 255)));
                end
            endcase
            send_item(KIND_EOS, 8'($urandom_range(0, 255)));
            repeat (40)
                send_item(($urandom_range(0, 7) == 0) ? KIND_EOS : KIND_DATA,
                          8'($urandom_range(0, 255)));
            send_item(KIND_EOS, 8'($urandom_range(0, 255)));
        end

        drain_results(20000);
        if (pending != 0)
            $display("%0d deframer outputs never arrived", pending);
        if (check_errors == 0 && pending == 0)
            $display("padded_record_deframer_tb: clean");
        else
            $display("padded_record_deframer_tb: errors");
        $finish;
    end

endmodule
